// ===== hdl/bbe3_pkg.sv =====
// ----------------------------------------------------------------------------
// bbe3_pkg: shared types and constants of the 3x3 binary border extractor
// pixel classes, register indexes and line-store sizing
// ----------------------------------------------------------------------------
package bbe3_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned EW_W       = COL_W + 1;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned PEND_W     = COL_W + 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned WIN_W      = 9 * CLS_W;
  localparam int unsigned LS_W       = 2 * CLS_W;

  localparam logic [PIX_W-1:0] PIX_FORE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BACK = 8'h00;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJACENCY    = 2'd2;

  typedef enum logic [CLS_W-1:0] {
    CLS_EMPTY = 2'd0,
    CLS_BACK  = 2'd1,
    CLS_FORE  = 2'd2,
    CLS_OTHER = 2'd3
  } cls_e;

  typedef struct packed {
    cls_e             cls;
    logic [COL_W-1:0] addr;
    logic [COL_W-1:0] out_col;
    logic [FH_W-1:0]  out_row;
  } slot_t;

endpackage

// ===== hdl/bbe3_ram.sv =====
// ----------------------------------------------------------------------------
// bbe3_ram: generic single-write, single-read RAM
// one write port and one read port with registered read data (read-first)
// ----------------------------------------------------------------------------
module bbe3_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/binary_border_extract_3x3.sv =====
// ----------------------------------------------------------------------------
// binary_border_extract_3x3: streaming border extraction over a 3x3 window
// marks 255 pixels on the frame edge or next to a background pixel
// ----------------------------------------------------------------------------
// throughput: one input beat per cycle unless the output stalls or the line
//   store is being cleared; a result passes stage one and the output register
//   once a beat one line plus one pixel behind it has completed its window
// reset: control state cleared, then a pass over all 1024 entries zeroes the
//   line store; s_axis_tready stays low meanwhile, config writes taken as ever
module binary_border_extract_3x3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bbe3_pkg::PIX_W-1:0]      s_axis_tdata,   // pixel_in
  input  logic                            s_axis_tuser,   // action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bbe3_pkg::PIX_W-1:0]      m_axis_tdata,   // pixel_out
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [bbe3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbe3_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bbe3_pkg::*;

  logic [FW_W-1:0]   fw_q;
  logic [FH_W-1:0]   fh_q;
  logic              adj_q;
  logic [EW_W-1:0]   w;
  logic [FH_W-1:0]   h;

  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [FH_W-1:0]   in_row_q, in_row_d;
  logic              col_wrap;
  logic [COL_W-1:0]  col0;
  logic [FH_W:0]     row_a;
  logic [FH_W-1:0]   row0;
  logic [EW_W-1:0]   col1;
  logic [FH_W:0]     row1;
  logic [COL_W-1:0]  out_col_c;
  logic [FH_W-1:0]   out_row_c;

  logic              clr_q;
  logic [COL_W-1:0]  clr_cnt_q;

  logic              en;
  logic              acc;
  logic              is_pixel;
  logic              take;
  logic              pend_avail;
  cls_e              cls_in;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic              inc, dec;

  slot_t             s1_q;
  logic              s1_vq;
  logic              s1_go;
  logic              fwd_q;
  logic [LS_W-1:0]   fwd_data_q;
  logic [LS_W-1:0]   ram_rd;
  logic [LS_W-1:0]   rd;
  logic [CLS_W-1:0]  up, mid;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [LS_W-1:0]   ram_wdata;

  logic [WIN_W-1:0]  win_q, win_d;
  logic [CLS_W-1:0]  centre;
  logic              emit;
  logic              edge_px;
  logic              hit4, hit8, hit;
  logic              last_px;
  logic [PIX_W-1:0]  res;

  logic              m_vq;
  logic [PIX_W-1:0]  m_data_q;
  logic              m_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FRAME_WIDTH_RST;
      fh_q  <= FRAME_HEIGHT_RST;
      adj_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q  <= cfg_data_i[FH_W-1:0];
        CFG_ADJACENCY:    adj_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) begin
      w = EW_W'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w = EW_W'(MAX_WIDTH);
    end else begin
      w = EW_W'(fw_q);
    end
    h = (fh_q == '0) ? FH_W'(1) : fh_q;
  end

  // input position, wrapped to the current frame size
  always_comb begin
    col_wrap = {1'b0, in_col_q} >= w;
    col0     = col_wrap ? '0 : in_col_q;
    row_a    = {1'b0, in_row_q} + (FH_W+1)'(col_wrap);
    row0     = (row_a >= {1'b0, h}) ? '0 : row_a[FH_W-1:0];

    if (col0 != '0) begin
      out_col_c = col0 - COL_W'(1);
    end else begin
      out_col_c = COL_W'(w - EW_W'(1));
    end

    if (h == FH_W'(1)) begin
      out_row_c = '0;
    end else if (col0 != '0) begin
      out_row_c = (row0 != '0) ? row0 - FH_W'(1) : h - FH_W'(1);
    end else if (row0 >= FH_W'(2)) begin
      out_row_c = row0 - FH_W'(2);
    end else if (row0 == FH_W'(1)) begin
      out_row_c = h - FH_W'(1);
    end else begin
      out_row_c = h - FH_W'(2);
    end

    col1 = {1'b0, col0} + EW_W'(1);
    row1 = {1'b0, row0} + (FH_W+1)'(1);
    if (col1 >= w) begin
      in_col_d = '0;
      in_row_d = (row1 >= {1'b0, h}) ? '0 : row1[FH_W-1:0];
    end else begin
      in_col_d = col1[COL_W-1:0];
      in_row_d = row0;
    end
  end

  // handshake and item qualification
  assign en            = !m_vq || m_axis_tready;
  assign s_axis_tready = en && !clr_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_pixel      = !s_axis_tuser;
  assign s1_go         = s1_vq && en;

  always_comb begin
    if (!is_pixel) begin
      cls_in = CLS_EMPTY;
    end else if (s_axis_tdata == PIX_BACK) begin
      cls_in = CLS_BACK;
    end else if (s_axis_tdata == PIX_FORE) begin
      cls_in = CLS_FORE;
    end else begin
      cls_in = CLS_OTHER;
    end
  end

  // flush counts only while pixels remain after the beat now in stage one
  assign pend_avail = !((pend_q == '0) || ((pend_q == PEND_W'(1)) && dec));
  assign take       = acc && (is_pixel || pend_avail);

  assign inc    = take && is_pixel && (pend_q != '1);
  assign dec    = s1_go && (centre != CLS_EMPTY) && (pend_q != '0);
  assign pend_d = pend_q + PEND_W'(inc) - PEND_W'(dec);

  // line store: [1:0] upper line, [3:2] middle line
  assign rd  = fwd_q ? fwd_data_q : ram_rd;
  assign up  = rd[CLS_W-1:0];
  assign mid = rd[LS_W-1:CLS_W];

  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_go;
      ram_waddr = s1_q.addr;
      ram_wdata = {s1_q.cls, mid};
    end
  end

  bbe3_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (take),
    .raddr_i (col0),
    .rdata_o (ram_rd)
  );

  // window and border decision
  always_comb begin
    win_d   = {s1_q.cls, mid, up, win_q[WIN_W-1:3*CLS_W]};
    centre  = win_d[9:8];
    emit    = s1_go && (centre != CLS_EMPTY);
    edge_px = (s1_q.out_row == '0) || (s1_q.out_row == h - FH_W'(1)) ||
              (s1_q.out_col == '0) || ({1'b0, s1_q.out_col} == w - EW_W'(1));
    last_px = (s1_q.out_row == h - FH_W'(1)) &&
              ({1'b0, s1_q.out_col} == w - EW_W'(1));
    hit4    = (win_d[7:6] == CLS_BACK) || (win_d[11:10] == CLS_BACK) ||
              (win_d[3:2] == CLS_BACK) || (win_d[15:14] == CLS_BACK);
    hit8    = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (win_d[CLS_W*i +: CLS_W] == CLS_BACK) begin
        hit8 = 1'b1;
      end
    end
    hit = edge_px || (adj_q ? hit8 : hit4);
    res = ((centre == CLS_FORE) && hit) ? PIX_FORE : PIX_BACK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      pend_q    <= '0;
      s1_vq     <= 1'b0;
      fwd_q     <= 1'b0;
      win_q     <= '0;
      m_vq      <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + COL_W'(1);
        if (clr_cnt_q == COL_W'(MAX_WIDTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (take) begin
        in_col_q <= in_col_d;
        in_row_q <= in_row_d;
        fwd_q    <= s1_go && (s1_q.addr == col0);
      end
      if (take) begin
        s1_vq <= 1'b1;
      end else if (s1_go) begin
        s1_vq <= 1'b0;
      end
      if (s1_go) begin
        win_q <= win_d;
      end
      if (en) begin
        m_vq <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q.cls     <= cls_in;
      s1_q.addr    <= col0;
      s1_q.out_col <= out_col_c;
      s1_q.out_row <= out_row_c;
      fwd_data_q   <= {s1_q.cls, mid};
    end
    if (emit) begin
      m_data_q <= res;
      m_last_q <= last_px;
    end
  end

  assign m_axis_tvalid = m_vq;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule
